### hdl/css_pkg.sv
// Shared types and codes for the cursor sequence store.
// Used by css_front, css_back and cursor_sequence_store_core; depends on nothing.
`default_nettype none

package css_pkg;

    // Command codes as they arrive on the input channel.
    localparam logic [2:0] CMD_START   = 3'd0;
    localparam logic [2:0] CMD_ADVANCE = 3'd1;
    localparam logic [2:0] CMD_INSERT  = 3'd2;
    localparam logic [2:0] CMD_ATTACH  = 3'd3;
    localparam logic [2:0] CMD_REMOVE  = 3'd4;
    localparam logic [2:0] CMD_QUERY   = 3'd5;

    // Status codes reported with every result.
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NO_ITEM = 2'd2;

    // Depth of the command queue between the front and back parts.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic [31:0] current_value;
        logic        has_current;
        logic [5:0]  count;
        logic [1:0]  status;
    } out_item_t;

    // Decoded operation; unused command codes fold into OP_QUERY.
    typedef enum logic [2:0] {
        OP_START,
        OP_ADVANCE,
        OP_INSERT,
        OP_ATTACH,
        OP_REMOVE,
        OP_QUERY
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] value;
    } op_item_t;

endpackage

`default_nettype wire

### hdl/css_front.sv
// Front part of the cursor sequence store: accepts items, decodes the command
// and holds decoded operations in a short queue. Depends on css_pkg.
`default_nettype none

module css_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_ready,
    input  wire css_pkg::in_item_t cmd_item,
    output logic                   q_valid,
    input  wire logic              q_pop,
    output css_pkg::op_item_t      q_item
);
    import css_pkg::*;

    op_item_t             entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_next;
    logic [Q_CNT_W-1:0]   fill_reg;
    logic [Q_CNT_W-1:0]   fill_next;
    logic                 push;
    logic                 pop;
    op_item_t             decoded;

    always_comb
    begin
        decoded.value = cmd_item.value;
        unique case (cmd_item.command)
            CMD_START:   decoded.op = OP_START;
            CMD_ADVANCE: decoded.op = OP_ADVANCE;
            CMD_INSERT:  decoded.op = OP_INSERT;
            CMD_ATTACH:  decoded.op = OP_ATTACH;
            CMD_REMOVE:  decoded.op = OP_REMOVE;
            default:     decoded.op = OP_QUERY;
        endcase
    end

    assign cmd_ready = (fill_reg != Q_CNT_W'(Q_DEPTH));
    assign q_valid   = (fill_reg != '0);
    assign q_item    = entry_reg[rd_ptr_reg];
    assign push      = cmd_valid && cmd_ready;
    assign pop       = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + Q_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

`default_nettype wire

### hdl/css_back.sv
// Back part of the cursor sequence store: executes queued operations against
// the element memory and holds the result register. Depends on css_pkg.
`default_nettype none

module css_back #(
    parameter int CAPACITY   = 32,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    output logic                   q_pop,
    input  wire css_pkg::op_item_t q_item,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output css_pkg::out_item_t     rsp_item
);
    import css_pkg::*;

    // Stored values never exceed the 32-bit input field.
    localparam int STORE_W = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int AW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW      = $clog2(CAPACITY + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SHIFT  = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_WRITE  = 3'd3;
    localparam logic [2:0] S_READ   = 3'd4;
    localparam logic [2:0] S_RESULT = 3'd5;

    logic [STORE_W-1:0] mem [CAPACITY];
    logic [STORE_W-1:0] rd_data_reg;

    logic [2:0]         state_reg,  state_next;
    logic [CW-1:0]      count_reg,  count_next;
    logic [CW-1:0]      cursor_reg, cursor_next;
    logic [1:0]         status_reg, status_next;
    logic [AW-1:0]      src_reg,    src_next;
    logic [AW-1:0]      end_reg,    end_next;
    logic               up_reg,     up_next;
    logic               ins_reg,    ins_next;
    logic [AW-1:0]      pos_reg,    pos_next;
    logic [STORE_W-1:0] val_reg,    val_next;
    logic               pend_reg,   pend_next;
    logic [AW-1:0]      pend_addr_reg, pend_addr_next;
    logic               res_has_reg, res_has_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_reg,    out_next;

    logic               has;
    logic               full;
    logic [CW-1:0]      place;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [STORE_W-1:0] wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               out_free;

    assign has      = (cursor_reg < count_reg);
    assign full     = (count_reg == CW'(CAPACITY));
    assign out_free = !out_valid_reg || rsp_ready;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cursor_next    = cursor_reg;
        status_next    = status_reg;
        src_next       = src_reg;
        end_next       = end_reg;
        up_next        = up_reg;
        ins_next       = ins_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        res_has_next   = res_has_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        out_next       = out_reg;
        q_pop          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = src_reg;
        place          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop       = 1'b1;
                    status_next = ST_DONE;
                    state_next  = S_READ;
                    val_next    = q_item.value[STORE_W-1:0];
                    unique case (q_item.op)
                        OP_START:
                        begin
                            cursor_next = '0;
                        end
                        OP_ADVANCE:
                        begin
                            if (has)
                            begin
                                cursor_next = cursor_reg + CW'(1);
                            end
                            else
                            begin
                                status_next = ST_NO_ITEM;
                            end
                        end
                        OP_INSERT, OP_ATTACH:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                if (q_item.op == OP_INSERT)
                                begin
                                    place = has ? cursor_reg : '0;
                                end
                                else
                                begin
                                    place = has ? cursor_reg + CW'(1) : count_reg;
                                end
                                pos_next    = AW'(place);
                                cursor_next = place;
                                count_next  = count_reg + CW'(1);
                                ins_next    = 1'b1;
                                // Entries from the insertion point up move one place up.
                                if (count_reg > place)
                                begin
                                    src_next   = AW'(count_reg - CW'(1));
                                    end_next   = AW'(place);
                                    up_next    = 1'b1;
                                    state_next = S_SHIFT;
                                end
                                else
                                begin
                                    state_next = S_WRITE;
                                end
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (has)
                            begin
                                count_next = count_reg - CW'(1);
                                ins_next   = 1'b0;
                                // Entries after the cursor move one place down.
                                if ((cursor_reg + CW'(1)) < count_reg)
                                begin
                                    src_next   = AW'(cursor_reg + CW'(1));
                                    end_next   = AW'(count_reg - CW'(1));
                                    up_next    = 1'b0;
                                    state_next = S_SHIFT;
                                end
                            end
                            else
                            begin
                                status_next = ST_NO_ITEM;
                            end
                        end
                        default:
                        begin
                            state_next = S_READ;
                        end
                    endcase
                end
            end
            S_SHIFT:
            begin
                rd_en          = 1'b1;
                rd_addr        = src_reg;
                pend_next      = 1'b1;
                pend_addr_next = up_reg ? src_reg + AW'(1) : src_reg - AW'(1);
                if (src_reg == end_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    src_next = up_reg ? src_reg - AW'(1) : src_reg + AW'(1);
                end
            end
            S_DRAIN:
            begin
                state_next = ins_reg ? S_WRITE : S_READ;
            end
            S_WRITE:
            begin
                state_next = S_READ;
            end
            S_READ:
            begin
                rd_en        = has;
                rd_addr      = AW'(cursor_reg);
                res_has_next = has;
                state_next   = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_next.current_value = res_has_reg ? 32'(rd_data_reg) : 32'd0;
                    out_next.has_current   = res_has_reg;
                    out_next.count         = 6'(count_reg);
                    out_next.status        = status_reg;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // One write port: the new value, or the element read in the previous cycle.
    always_comb
    begin
        if (state_reg == S_WRITE)
        begin
            wr_en   = 1'b1;
            wr_addr = pos_reg;
            wr_data = val_reg;
        end
        else
        begin
            wr_en   = pend_reg;
            wr_addr = pend_addr_reg;
            wr_data = rd_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cursor_reg    <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg    <= status_next;
        src_reg       <= src_next;
        end_reg       <= end_next;
        up_reg        <= up_next;
        ins_reg       <= ins_next;
        pos_reg       <= pos_next;
        val_reg       <= val_next;
        pend_addr_reg <= pend_addr_next;
        res_has_reg   <= res_has_next;
        out_reg       <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_item  = out_reg;

endmodule

`default_nettype wire

### hdl/cursor_sequence_store_core.sv
// Cursor sequence store: an accepted item waits in the front queue; the back part then
// passes read and result for start, advance, query, rejected commands and a remove that
// moves nothing, with a write state before read for an unshifted write. Insert and attach
// that move elements pass shift, drain and write; remove passes shift and drain. The single
// write port moves one element per cycle; the back part takes the next item only in idle.
// Reset clears count, cursor and handshakes; the store is not cleared.
`default_nettype none

module cursor_sequence_store_core #(
    parameter int CAPACITY   = 32,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_ready,
    input  wire css_pkg::in_item_t cmd_item,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output css_pkg::out_item_t     rsp_item
);
    import css_pkg::*;

    // The front part decodes each item into an operation and queues it, so a new
    // item can be taken while the back part is still shifting the store.
    logic     q_valid;
    logic     q_pop;
    op_item_t q_item;

    css_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_item  (cmd_item),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item)
    );

    // The back part owns the element memory, the count and the cursor. It walks
    // the stored elements one per cycle for insert, attach and remove, then reads
    // the element at the cursor and places the result in its output register.
    css_back #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item)
    );

endmodule

`default_nettype wire

### dv/css_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the cursor sequence store testbench: a behavioral model of the
// ordered list and its cursor, plus an in-order response checker. Depends on css_pkg.

package css_tb_pkg;

    import css_pkg::*;

    localparam int          ELEMENT_SLOTS = 32;
    localparam int          ELEMENT_BITS  = 32;
    localparam logic [31:0] VALUE_MASK    = 32'hFFFF_FFFF >> (32 - ELEMENT_BITS);

    class sequence_scoreboard;

        logic [31:0] elements [ELEMENT_SLOTS];
        int          fill = 0;
        int          position = 0;
        out_item_t   expected_responses [$];

        int errors = 0;
        int commands = 0;
        int responses = 0;
        int peak_fill = 0;
        int done_count = 0;
        int full_rejects = 0;
        int no_item_rejects = 0;

        // Applies one command to the model list and returns the response it should give.
        function out_item_t apply_command(in_item_t c);
            out_item_t   r;
            logic [31:0] v;
            logic [1:0]  st;
            v  = c.value & VALUE_MASK;
            st = ST_DONE;
            case (c.command)
                CMD_START:
                    position = 0;
                CMD_ADVANCE:
                    if (position < fill)
                        position++;
                    else
                        st = ST_NO_ITEM;
                CMD_INSERT:
                    if (fill >= ELEMENT_SLOTS)
                        st = ST_FULL;
                    else
                    begin
                        if (position >= fill)
                            position = 0;
                        for (int i = fill; i > position; i--)
                            elements[i] = elements[i - 1];
                        elements[position] = v;
                        fill++;
                    end
                CMD_ATTACH:
                    if (fill >= ELEMENT_SLOTS)
                        st = ST_FULL;
                    else if (position < fill)
                    begin
                        for (int i = fill; i > position + 1; i--)
                            elements[i] = elements[i - 1];
                        elements[position + 1] = v;
                        position++;
                        fill++;
                    end
                    else
                    begin
                        elements[fill] = v;
                        position = fill;
                        fill++;
                    end
                CMD_REMOVE:
                    if (position < fill)
                    begin
                        for (int i = position; i + 1 < fill; i++)
                            elements[i] = elements[i + 1];
                        fill--;
                    end
                    else
                        st = ST_NO_ITEM;
                default:
                    ;
            endcase
            if (position < fill)
            begin
                r.current_value = elements[position];
                r.has_current   = 1'b1;
            end
            else
            begin
                r.current_value = '0;
                r.has_current   = 1'b0;
            end
            r.count  = 6'(fill);
            r.status = st;
            return r;
        endfunction

        function void note_command(in_item_t c);
            out_item_t r;
            r = apply_command(c);
            commands++;
            if (fill > peak_fill)
                peak_fill = fill;
            case (r.status)
                ST_FULL:    full_rejects++;
                ST_NO_ITEM: no_item_rejects++;
                default:    done_count++;
            endcase
            expected_responses.push_back(r);
        endfunction

        function void check_response(out_item_t got);
            out_item_t exp;
            responses++;
            if (expected_responses.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: response %0d arrived with no command outstanding: %p",
                             responses, got);
                return;
            end
            exp = expected_responses.pop_front();
            if (got.current_value !== exp.current_value || got.has_current !== exp.has_current
                || got.count !== exp.count || got.status !== exp.status)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: response %0d: expected value=%h current=%b count=%0d status=%0d, got value=%h current=%b count=%0d status=%0d",
                             responses, exp.current_value, exp.has_current, exp.count,
                             exp.status, got.current_value, got.has_current, got.count,
                             got.status);
            end
        endfunction

        function int outstanding();
            return expected_responses.size();
        endfunction

        // Any response still owed at the end of the run counts against it.
        function int close_out();
            if (expected_responses.size() != 0)
            begin
                errors += expected_responses.size();
                $display("ERROR: %0d responses never arrived", expected_responses.size());
            end
            return errors;
        endfunction

    endclass

endpackage

### dv/tb_top.sv
`timescale 1ns / 1ps
// Top-level testbench for cursor_sequence_store_core: drives commands, throttles the
// response channel and checks every response. Depends on css_pkg and css_tb_pkg.

module tb_top;

    import css_pkg::*;
    import css_tb_pkg::*;

    // Codes outside the defined command set; the block treats them like a query.
    localparam logic [2:0] CODE_SIX   = 3'd6;
    localparam logic [2:0] CODE_SEVEN = 3'd7;

    localparam int RANDOM_ITEMS   = 1580;
    localparam int QUIET_ITEMS    = 200;   // no idling on either side for the final items
    localparam int HOLD_CYCLES    = 400;   // the long receiver stall
    localparam int HOLD_AFTER     = 300;   // responses seen before that stall begins
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake on either channel
    localparam int DRAIN_CYCLES   = 60;    // settle time after the last response

    typedef enum int
    {
        MODE_FILL,
        MODE_DRAIN,
        MODE_WALK
    } traffic_mode_t;

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_ready;
    in_item_t  cmd_item;
    logic      rsp_valid;
    logic      rsp_ready;
    out_item_t rsp_item;

    sequence_scoreboard sb = new();

    // Set by the stimulus thread once the final stretch begins; both sides stop idling.
    bit quiet_tail = 1'b0;
    bit hold_done  = 1'b0;

    cursor_sequence_store_core #(
        .CAPACITY   (ELEMENT_SLOTS),
        .DATA_WIDTH (ELEMENT_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_item  (cmd_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Offers one command from the falling edge and holds it until the block takes it.
    // Valid is left high afterwards, so back-to-back commands only change the payload.
    task automatic send_command(input in_item_t c);
        @(negedge clk);
        cmd_item  = c;
        cmd_valid = 1'b1;
        do
            @(posedge clk);
        while (!cmd_ready);
        sb.note_command(c);
    endtask

    task automatic pause_sender(input int cycles);
        @(negedge clk);
        cmd_valid = 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    function automatic in_item_t make_command(input logic [2:0] code, input logic [31:0] v);
        in_item_t c;
        c.command = code;
        c.value   = v;
        return c;
    endfunction

    // Random command whose mix depends on the traffic mode: fill phases push the list
    // to capacity, drain phases empty it, walk phases move the cursor around.
    function automatic in_item_t random_command(input traffic_mode_t mode);
        in_item_t c;
        int       pick;
        int       vpick;
        pick  = $urandom_range(0, 99);
        vpick = $urandom_range(0, 9);
        if (vpick == 0)
            c.value = 32'h0000_0000;
        else if (vpick == 1)
            c.value = 32'hFFFF_FFFF;
        else
            c.value = $urandom;
        case (mode)
            MODE_FILL:
                if (pick < 40)      c.command = CMD_INSERT;
                else if (pick < 75) c.command = CMD_ATTACH;
                else if (pick < 85) c.command = CMD_ADVANCE;
                else if (pick < 90) c.command = CMD_START;
                else if (pick < 95) c.command = CMD_REMOVE;
                else                c.command = CMD_QUERY;
            MODE_DRAIN:
                if (pick < 45)      c.command = CMD_REMOVE;
                else if (pick < 65) c.command = CMD_ADVANCE;
                else if (pick < 75) c.command = CMD_START;
                else if (pick < 85) c.command = CMD_INSERT;
                else if (pick < 90) c.command = CMD_ATTACH;
                else if (pick < 95) c.command = CMD_QUERY;
                else                c.command = $urandom_range(0, 1) ? CODE_SIX : CODE_SEVEN;
            default:
                if (pick < 25)      c.command = CMD_ADVANCE;
                else if (pick < 40) c.command = CMD_START;
                else if (pick < 55) c.command = CMD_INSERT;
                else if (pick < 70) c.command = CMD_ATTACH;
                else if (pick < 85) c.command = CMD_REMOVE;
                else if (pick < 95) c.command = CMD_QUERY;
                else                c.command = $urandom_range(0, 1) ? CODE_SIX : CODE_SEVEN;
        endcase
        return c;
    endfunction

    // Response monitor: every accepted response goes to the scoreboard in order.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && rsp_ready)
                sb.check_response(rsp_item);
        end
    end

    // Receiver: random stalls between open stretches, and once in the run a long hold-off
    // so the internal queue fills and the block stops taking commands.
    initial
    begin
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && sb.responses >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                rsp_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (!quiet_tail && $urandom_range(0, 99) < 15)
            begin
                rsp_ready = 1'b0;
                repeat ($urandom_range(1, 13) - 1) @(negedge clk);
            end
            else
            begin
                rsp_ready = 1'b1;
                repeat ($urandom_range(1, 40) - 1) @(negedge clk);
            end
        end
    end

    // Watchdog: a long run of cycles with no handshake on either channel means a hang.
    initial
    begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("ERROR: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // Stimulus and end of run.
    initial
    begin
        traffic_mode_t mode;
        int            phase_left;
        in_item_t      directed [$];

        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd_item  = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed opening. The list contents in the comments follow from the sequence.
        directed.push_back(make_command(CMD_QUERY,   $urandom));     // empty after reset
        directed.push_back(make_command(CMD_START,   $urandom));     // start on empty list
        directed.push_back(make_command(CMD_ADVANCE, $urandom));     // no current item
        directed.push_back(make_command(CMD_REMOVE,  $urandom));     // no current item
        directed.push_back(make_command(CMD_INSERT,  32'hFFFF_FFFF)); // into empty list
        directed.push_back(make_command(CMD_ATTACH,  32'h0000_0000)); // after current
        directed.push_back(make_command(CMD_INSERT,  32'h5A5A_A5A5)); // before current
        directed.push_back(make_command(CMD_START,   $urandom));
        directed.push_back(make_command(CMD_ADVANCE, $urandom));
        directed.push_back(make_command(CMD_ADVANCE, $urandom));
        directed.push_back(make_command(CMD_ADVANCE, $urandom));     // steps past the end
        directed.push_back(make_command(CMD_ADVANCE, $urandom));     // rejected, no item
        directed.push_back(make_command(CMD_ATTACH,  32'h8000_0001)); // goes to the end
        directed.push_back(make_command(CMD_ADVANCE, $urandom));     // past the end again
        directed.push_back(make_command(CMD_INSERT,  32'h1234_5678)); // goes to the front
        directed.push_back(make_command(CMD_REMOVE,  $urandom));     // shifts the rest down
        directed.push_back(make_command(CMD_ADVANCE, $urandom));
        directed.push_back(make_command(CMD_ADVANCE, $urandom));
        directed.push_back(make_command(CMD_ADVANCE, $urandom));     // cursor on last entry
        directed.push_back(make_command(CMD_REMOVE,  $urandom));     // removes the last one
        directed.push_back(make_command(CMD_REMOVE,  $urandom));     // rejected, no item
        directed.push_back(make_command(CODE_SIX,    $urandom));
        directed.push_back(make_command(CODE_SEVEN,  $urandom));
        directed.push_back(make_command(CMD_QUERY,   $urandom));
        foreach (directed[i])
            send_command(directed[i]);

        // Random part. The first phase fills the list so the full case comes early;
        // later phases pick a mode at random.
        mode       = MODE_FILL;
        phase_left = 60;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (phase_left == 0)
            begin
                mode       = traffic_mode_t'($urandom_range(0, 2));
                phase_left = $urandom_range(20, 60);
            end
            phase_left--;
            if (n == RANDOM_ITEMS - QUIET_ITEMS)
                quiet_tail = 1'b1;
            if (!quiet_tail && $urandom_range(0, 99) < 12)
                pause_sender($urandom_range(1, 13));
            send_command(random_command(mode));
        end
        @(negedge clk);
        cmd_valid = 1'b0;

        // Wait for every owed response, then let the block settle; the watchdog bounds
        // both waits.
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d commands and checked %0d responses; peak fill %0d of %0d.",
                 sb.commands, sb.responses, sb.peak_fill, ELEMENT_SLOTS);
        $display("Outcomes: %0d done, %0d rejected full, %0d rejected with no current item.",
                 sb.done_count, sb.full_rejects, sb.no_item_rejects);
        if (sb.close_out() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
